### rtl/ipwd_pkg.sv
// Shared types, constants and code table of the IR pulse-width command decoder.
`default_nettype none

package ipwd_pkg;

	localparam int unsigned NUM_CFG = 8;
	localparam int unsigned CFG_IDX_W = $clog2(NUM_CFG);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS = 3'd7;

	typedef logic [NUM_CFG-1:0][15:0] cfg_t;

	localparam cfg_t CFG_RESET = {
		16'd200, 16'd3000, 16'd1500, 16'd700,
		16'd2400, 16'd1600, 16'd10000, 16'd8000
	};

	// Command codes
	localparam logic [4:0] CMD_GROUP_OFF = 5'd0;
	localparam logic [4:0] CMD_GROUP_ON  = 5'd1;
	localparam logic [4:0] CMD_DIM       = 5'd4;
	localparam logic [4:0] CMD_LEVEL_UP  = 5'd5;
	localparam logic [4:0] CMD_ADDR_ONLY = 5'd16;
	localparam logic [4:0] CMD_UNKNOWN   = 5'd31;

	// Bit counts seen at the end pulse of a valid frame
	localparam logic [3:0] BC_HOUSE_FRAME = 4'd9;
	localparam logic [3:0] BC_UNIT_FRAME  = 4'd11;

	localparam int unsigned IPWD_UNIT_RESET_MS = 2000;
	localparam int unsigned IPWD_DEFAULT_HOUSE = 0;

	localparam logic [15:0][3:0] CODE_TABLE = {
		4'hC, 4'h4, 4'h8, 4'h0, 4'hB, 4'h3, 4'hF, 4'h7,
		4'hD, 4'h5, 4'h9, 4'h1, 4'hA, 4'h2, 4'hE, 4'h6
	};

	typedef struct packed {
		logic [3:0]  bit_count;
		logic [15:0] shift_buffer;
		logic [31:0] last_end_ms;
		logic [3:0]  house;
		logic [4:0]  unit;
		logic [4:0]  command;
	} dec_state_t;

	typedef struct packed {
		logic [3:0] house_index;
		logic [4:0] unit_number;
		logic [4:0] command_code;
		logic       is_repeat;
	} dec_result_t;

	// Inverse lookup of the code table
	function automatic logic [3:0] table_index(input logic [3:0] nib);
		logic [3:0] idx;
		idx = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (CODE_TABLE[i] == nib) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/ir_pulse_width_command_decoder.sv
// Top level of the IR pulse-width command decoder: handshakes, registers, state.
`default_nettype none

// Each input beat carries the width of one IR low pulse in microseconds and
// the millisecond timestamp of its rising edge. The beat is captured in an
// input register; once the output register can take a result, one pass of
// shallow decode logic updates the frame state (bit count, shift buffer,
// house, unit, command, last frame time) and, for unit/command frames and
// repeats with a broadcast command or a selected unit, loads a result beat
// into the output register. Throughput is one pulse per cycle while no
// result beat is stalled; m_tvalid rises when the decoded result is loaded
// into the output register. The only stall source is a result beat held by
// a low m_tready, which freezes the input register (and with it s_tready)
// until the output register drains. House frames, bit pulses and rejected
// frames produce no beat. Timing windows are written through the cfg port
// (index = register number, resets to the standard values) and must only change while no pulse is in flight.

module ir_pulse_width_command_decoder
	import ipwd_pkg::*;
#(
	parameter int unsigned UNIT_RESET_MS = IPWD_UNIT_RESET_MS,
	parameter int unsigned DEFAULT_HOUSE = IPWD_DEFAULT_HOUSE
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// pulse input
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire [63:0]           s_tdata,  // low_width_us[31:0], now_ms[63:32]
	// decoded command output
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [15:0]          m_tdata,  // house_index[3:0], unit_number[8:4],
	                                       // command_code[13:9], zero[15:14]
	output logic                 m_tuser,  // is_repeat[0]
	// configuration writes
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [15:0]           cfg_data
);

	cfg_t        cfg_q;
	dec_state_t  st_q, st_nxt;
	dec_result_t res, out_q;
	logic        res_valid;
	logic        out_valid_q;

	// input register
	logic        v_s1;
	logic [31:0] width_s1, now_s1;

	logic        advance;

	// decode the held beat once the output register can take a result
	assign advance  = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			width_s1 <= s_tdata[31:0];
			now_s1   <= s_tdata[63:32];
		end
	end

	ipwd_step #(
		.UNIT_RESET_MS(UNIT_RESET_MS),
		.DEFAULT_HOUSE(DEFAULT_HOUSE)
	) u_step (
		.cfg          (cfg_q),
		.st           (st_q),
		.low_width_us (width_s1),
		.now_ms       (now_s1),
		.st_nxt       (st_nxt),
		.res_valid    (res_valid),
		.res          (res)
	);

	// frame state: idle, empty buffer, no last frame, default house
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.bit_count    <= 4'd0;
			st_q.shift_buffer <= 16'd0;
			st_q.last_end_ms  <= 32'd0;
			st_q.house        <= 4'(DEFAULT_HOUSE);
			st_q.unit         <= 5'd0;
			st_q.command      <= CMD_UNKNOWN;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.command_code, out_q.unit_number, out_q.house_index};
	assign m_tuser  = out_q.is_repeat;

	// state only moves on a decoded beat
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("decoder state changed without a decoded beat");

	// a stalled result blocks decoding
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !advance)
		else $error("decode while result beat is stalled");

	// empty input register always takes a beat
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input not ready with empty input register");

	// bit count stays within one overlong step of a unit frame
	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_count <= BC_UNIT_FRAME + 4'd1)
		else $error("bit count out of range");

	// the unknown-command marker is never sent
	a_no_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.command_code != CMD_UNKNOWN))
		else $error("unknown command marker emitted");

endmodule

`default_nettype wire

### rtl/ipwd_step.sv
// Per-pulse decode: next decoder state and optional result for one pulse.
`default_nettype none

module ipwd_step
	import ipwd_pkg::*;
#(
	parameter int unsigned UNIT_RESET_MS = IPWD_UNIT_RESET_MS,
	parameter int unsigned DEFAULT_HOUSE = IPWD_DEFAULT_HOUSE
) (
	input  var cfg_t        cfg,
	input  var dec_state_t  st,
	input  wire [31:0]      low_width_us,
	input  wire [31:0]      now_ms,
	output var dec_state_t  st_nxt,
	output logic            res_valid,
	output var dec_result_t res
);

	logic        is_start, is_one, is_zero, is_end;
	logic        have_last, timeout, repeat_hit;
	logic [31:0] elapsed;
	logic        cmp4_ok, cmp5_ok;
	logic        try_emit, rep;
	logic [3:0]  bit_pos;
	logic [3:0]  nib;

	always_comb begin
		is_start = (low_width_us >= 32'(cfg[CFG_START_MIN]))
			&& (low_width_us <= 32'(cfg[CFG_START_MAX]));
		is_one   = (low_width_us >= 32'(cfg[CFG_ONE_MIN]))
			&& (low_width_us <= 32'(cfg[CFG_ONE_MAX]));
		is_zero  = (low_width_us >= 32'(cfg[CFG_ZERO_MIN]))
			&& (low_width_us <= 32'(cfg[CFG_ZERO_MAX]));
		is_end   = low_width_us > 32'(cfg[CFG_END_MIN]);

		have_last  = st.last_end_ms != 32'd0;
		elapsed    = now_ms - st.last_end_ms;
		timeout    = have_last
			&& ((elapsed > 32'(UNIT_RESET_MS)) || (st.last_end_ms > now_ms));
		repeat_hit = have_last && (now_ms > st.last_end_ms)
			&& (elapsed < 32'(cfg[CFG_REPEAT_MS]));

		// data bits against their complements
		cmp5_ok = 1'b1;
		for (int i = 0; i < 5; i++) begin
			if (st.shift_buffer[15-i] == st.shift_buffer[10-i]) begin
				cmp5_ok = 1'b0;
			end
		end
		cmp4_ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (st.shift_buffer[15-i] == st.shift_buffer[11-i]) begin
				cmp4_ok = 1'b0;
			end
		end

		bit_pos = 4'(5'd16 - 5'(st.bit_count));
		nib     = st.shift_buffer[15:12];

		st_nxt   = st;
		try_emit = 1'b0;
		rep      = 1'b0;

		if (is_start) begin
			if (timeout) begin
				st_nxt.house = 4'(DEFAULT_HOUSE);
				st_nxt.unit  = 5'd0;
			end
			if (repeat_hit) begin
				st_nxt.last_end_ms = now_ms;
				try_emit = 1'b1;
				rep      = 1'b1;
			end else begin
				st_nxt.last_end_ms  = 32'd0;
				st_nxt.shift_buffer = 16'd0;
				st_nxt.bit_count    = 4'd1;
			end
		end else if (st.bit_count == 4'd0) begin
			// idle: stray pulse ignored
		end else if (st.bit_count > BC_UNIT_FRAME) begin
			st_nxt.bit_count = 4'd0;
		end else if (is_one) begin
			st_nxt.shift_buffer[bit_pos] = 1'b1;
			st_nxt.bit_count = st.bit_count + 4'd1;
		end else if (is_zero) begin
			st_nxt.bit_count = st.bit_count + 4'd1;
		end else begin
			st_nxt.bit_count = 4'd0;
			if (is_end) begin
				if (st.bit_count == BC_UNIT_FRAME && cmp5_ok) begin
					st_nxt.last_end_ms = now_ms;
					try_emit = 1'b1;
					if (st.shift_buffer[11]) begin
						st_nxt.unit    = {1'b0, table_index(nib)} + 5'd1;
						st_nxt.command = CMD_ADDR_ONLY;
					end else begin
						st_nxt.command = {1'b0, nib};
					end
				end else if (st.bit_count == BC_HOUSE_FRAME && cmp4_ok) begin
					st_nxt.last_end_ms = now_ms;
					st_nxt.house   = table_index(nib);
					st_nxt.unit    = 5'd0;
					st_nxt.command = CMD_UNKNOWN;
				end
			end
		end

		res.house_index  = st_nxt.house;
		res.command_code = st_nxt.command;
		res.is_repeat    = rep;
		res.unit_number  = st_nxt.unit;
		res_valid        = 1'b0;
		if (st_nxt.command inside {CMD_GROUP_OFF, CMD_GROUP_ON, CMD_DIM, CMD_LEVEL_UP}) begin
			res.unit_number = 5'd0;
			res_valid       = try_emit;
		end else if (st_nxt.unit != 5'd0) begin
			res_valid = try_emit;
		end
	end

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the IR pulse-width command decoder.
`default_nettype none

module testbench
	import ipwd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Quiet cycles (no beat on any channel) before the run is declared hung.
	localparam int QUIET_LIMIT = 5000;
	// Cycles to let the last pulse clear the two-stage pipe before a cfg write.
	localparam int SETTLE_CYCLES = 8;
	// Length of the deliberate receiver hold-off.
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_PULSES = 225;
	localparam int NUM_PHASES = 6;

	// ------------------------------------------------------------------
	// Scoreboard: shadows the decoder state and queues predicted commands
	// ------------------------------------------------------------------
	class command_scoreboard;
		logic [15:0]   regs [NUM_CFG];
		int            bit_count;
		logic [15:0]   shift_bits;
		logic [31:0]   last_end_ms;
		logic [3:0]    house;
		logic [4:0]    unit;
		logic [4:0]    command;
		dec_result_t   pending_cmds [$];
		int            errors;

		function new();
			for (int i = 0; i < NUM_CFG; i++) begin
				regs[i] = CFG_RESET[i];
			end
			bit_count   = 0;
			shift_bits  = '0;
			last_end_ms = '0;
			house       = 4'(IPWD_DEFAULT_HOUSE);
			unit        = '0;
			command     = CMD_UNKNOWN;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			regs[idx] = data;
		endfunction

		function int pending();
			return pending_cmds.size();
		endfunction

		// inverse of the house/unit code table
		function logic [3:0] code_to_index(logic [3:0] code);
			case (code)
				4'h6: return 4'd0;
				4'hE: return 4'd1;
				4'h2: return 4'd2;
				4'hA: return 4'd3;
				4'h1: return 4'd4;
				4'h9: return 4'd5;
				4'h5: return 4'd6;
				4'hD: return 4'd7;
				4'h7: return 4'd8;
				4'hF: return 4'd9;
				4'h3: return 4'd10;
				4'hB: return 4'd11;
				4'h0: return 4'd12;
				4'h8: return 4'd13;
				4'h4: return 4'd14;
				default: return 4'd15;
			endcase
		endfunction

		// first n bits from the top must be followed by their inverses
		function bit complements_ok(logic [15:0] b, int n);
			for (int i = 0; i < n; i++) begin
				if (b[15-i] == b[15-n-i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		// broadcast commands go out with unit 0, others need a selected unit
		function void queue_command(bit rep);
			dec_result_t r;
			if (command == CMD_GROUP_OFF || command == CMD_GROUP_ON ||
			    command == CMD_DIM || command == CMD_LEVEL_UP) begin
				r.unit_number = '0;
			end else if (unit != 0) begin
				r.unit_number = unit;
			end else begin
				return;
			end
			r.house_index  = house;
			r.command_code = command;
			r.is_repeat    = rep;
			pending_cmds.push_back(r);
		endfunction

		function void note_pulse(logic [31:0] width, logic [31:0] stamp);
			logic [31:0] since;
			int          held_count;
			logic [15:0] held_bits;
			since = stamp - last_end_ms;
			// start window wins over all others
			if (width >= regs[CFG_START_MIN] && width <= regs[CFG_START_MAX]) begin
				if (last_end_ms != 0 &&
				    (since > IPWD_UNIT_RESET_MS || last_end_ms > stamp)) begin
					house = 4'(IPWD_DEFAULT_HOUSE);
					unit  = '0;
				end
				if (last_end_ms != 0 && stamp > last_end_ms &&
				    since < regs[CFG_REPEAT_MS]) begin
					last_end_ms = stamp;
					queue_command(1'b1);
					return;
				end
				last_end_ms = '0;
				shift_bits  = '0;
				bit_count   = 1;
				return;
			end
			if (bit_count == 0) return;
			// overlong frame: drop back to idle on the next pulse
			if (bit_count > 11) begin
				bit_count = 0;
				return;
			end
			if (width >= regs[CFG_ONE_MIN] && width <= regs[CFG_ONE_MAX]) begin
				shift_bits[16-bit_count] = 1'b1;
				bit_count++;
				return;
			end
			if (width >= regs[CFG_ZERO_MIN] && width <= regs[CFG_ZERO_MAX]) begin
				bit_count++;
				return;
			end
			held_count = bit_count;
			held_bits  = shift_bits;
			bit_count  = 0;
			if (width <= regs[CFG_END_MIN]) return;
			if (held_count == int'(BC_UNIT_FRAME) && complements_ok(held_bits, 5)) begin
				last_end_ms = stamp;
				if (held_bits[11]) begin
					unit    = 5'(code_to_index(held_bits[15:12])) + 5'd1;
					command = CMD_ADDR_ONLY;
				end else begin
					command = {1'b0, held_bits[15:12]};
				end
				queue_command(1'b0);
				return;
			end
			if (held_count == int'(BC_HOUSE_FRAME) && complements_ok(held_bits, 4)) begin
				last_end_ms = stamp;
				house       = code_to_index(held_bits[15:12]);
				unit        = '0;
				command     = CMD_UNKNOWN;
			end
		endfunction

		function void report(string field, int exp_val, int act_val);
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d",
			         $time, field, exp_val, act_val);
		endfunction

		function void check_command(logic [15:0] tdata, logic tuser);
			dec_result_t want;
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none actual tdata %h tuser %b",
				         $time, tdata, tuser);
				return;
			end
			want = pending_cmds.pop_front();
			if (tdata[3:0] !== want.house_index)
				report("house_index", want.house_index, tdata[3:0]);
			if (tdata[8:4] !== want.unit_number)
				report("unit_number", want.unit_number, tdata[8:4]);
			if (tdata[13:9] !== want.command_code)
				report("command_code", want.command_code, tdata[13:9]);
			if (tdata[15:14] !== 2'b00)
				report("tdata pad", 0, tdata[15:14]);
			if (tuser !== want.is_repeat)
				report("is_repeat", want.is_repeat, tuser);
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT and signals
	// ------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;   // low_width_us[31:0], now_ms[63:32]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // house[3:0], unit[8:4], command[13:9], zero[15:14]
	logic                 m_tuser;   // is_repeat[0]
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	ir_pulse_width_command_decoder #(
		.UNIT_RESET_MS(IPWD_UNIT_RESET_MS),
		.DEFAULT_HOUSE(IPWD_DEFAULT_HOUSE)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	command_scoreboard sb = new();

	logic [31:0] clock_ms;     // emulated millisecond timer fed with each pulse
	int          ms_step;      // max timer advance between pulses of one frame
	int          pulses_sent;  // pulses that exercise the decoder (noise excluded)
	bit          steady;       // no random idling on either side
	bit          hold_req;     // ask the receiver for one long hold-off
	int          quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Receiver: random backpressure, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// block fills up behind this and must stall s_tready
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready = steady || ($urandom_range(99) >= 30);
		end
	end

	// result beats are checked against the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_command(m_tdata, m_tuser);
		end
	end

	// watchdog: any accepted beat on any channel counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no beat for %0d cycles, %0d results outstanding",
		         $time, QUIET_LIMIT, sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [31:0] pick_in(logic [31:0] lo, logic [31:0] hi);
		if (lo <= hi) return $urandom_range(hi, lo);
		return $urandom_range(32'd65535, 32'd0);
	endfunction

	function automatic logic [31:0] start_w();
		return pick_in(sb.regs[CFG_START_MIN], sb.regs[CFG_START_MAX]);
	endfunction

	function automatic logic [31:0] one_w();
		return pick_in(sb.regs[CFG_ONE_MIN], sb.regs[CFG_ONE_MAX]);
	endfunction

	function automatic logic [31:0] zero_w();
		return pick_in(sb.regs[CFG_ZERO_MIN], sb.regs[CFG_ZERO_MAX]);
	endfunction

	// end pulse: strictly above end_min, now and then anywhere up to 2^32-1
	function automatic logic [31:0] end_w();
		logic [31:0] lo;
		lo = {16'd0, sb.regs[CFG_END_MIN]} + 32'd1;
		if ($urandom_range(7) == 0) return lo + $urandom_range(32'hFFFF_FFFF - lo, 0);
		return lo + $urandom_range(20000, 0);
	endfunction

	function automatic logic [31:0] tick();
		clock_ms = clock_ms + $urandom_range(ms_step, 0);
		return clock_ms;
	endfunction

	// timer jump between frames: mostly past the repeat window, sometimes
	// past the idle timeout, a short step, backwards, to zero, near the wrap or anywhere
	task automatic advance_clock();
		int r;
		r = $urandom_range(99);
		ms_step = 2;
		if (r < 60)
			clock_ms = clock_ms + sb.regs[CFG_REPEAT_MS] + $urandom_range(400, 0);
		else if (r < 72)
			clock_ms = clock_ms + $urandom_range(6000, 2001);
		else if (r < 78)
			clock_ms = clock_ms + $urandom_range(150, 0);
		else if (r < 84)
			clock_ms = clock_ms - $urandom_range(1000, 1);
		else if (r < 88) begin
			clock_ms = '0;
			ms_step  = 0;
		end else if (r < 92)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(40, 0);
		else
			clock_ms = $urandom;
	endtask

	// one pulse beat; inputs only change on the falling edge
	task automatic send_pulse(input logic [31:0] width, input logic [31:0] stamp,
	                          input bit tally = 1'b1);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {stamp, width};
		do @(posedge clk); while (!s_tready);
		sb.note_pulse(width, stamp);
		if (tally) pulses_sent++;
	endtask

	// start pulse, nbits data pulses MSB first from bit 15, closing pulse
	task automatic send_frame(input logic [15:0] pattern, input int nbits,
	                          input logic [31:0] last_w);
		send_pulse(start_w(), clock_ms);
		for (int i = 0; i < nbits; i++) begin
			send_pulse(pattern[15-i] ? one_w() : zero_w(), tick());
		end
		send_pulse(last_w, tick());
	endtask

	function automatic logic [15:0] unit_pattern(logic [3:0] nib, logic flag);
		return {nib, flag, ~{nib, flag}, 6'd0};
	endfunction

	function automatic logic [15:0] house_pattern(logic [3:0] nib);
		return {nib, ~nib, 8'd0};
	endfunction

	task automatic send_repeat();
		int span;
		span = (sb.regs[CFG_REPEAT_MS] > 300) ? 300 : sb.regs[CFG_REPEAT_MS] + 2;
		if (sb.last_end_ms != 0 && $urandom_range(3) != 0)
			clock_ms = sb.last_end_ms + $urandom_range(span, 0);
		else
			advance_clock();
		send_pulse(start_w(), clock_ms);
	endtask

	// drop valid, wait for every predicted command, then let the pipe clear
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	function automatic cfg_t phase_config(int phase);
		cfg_t c;
		logic [15:0] lo;
		c = CFG_RESET;
		case (phase)
			1: begin  // single-value windows, longest repeat window
				c[CFG_START_MIN] = 16'd9000;  c[CFG_START_MAX] = 16'd9000;
				c[CFG_ONE_MIN]   = 16'd2000;  c[CFG_ONE_MAX]   = 16'd2000;
				c[CFG_ZERO_MIN]  = 16'd1000;  c[CFG_ZERO_MAX]  = 16'd1000;
				c[CFG_END_MIN]   = 16'd2999;  c[CFG_REPEAT_MS] = 16'hFFFF;
			end
			2: begin  // everything at the bottom, repeats disabled
				c[CFG_START_MIN] = 16'd0;  c[CFG_START_MAX] = 16'd0;
				c[CFG_ONE_MIN]   = 16'd1;  c[CFG_ONE_MAX]   = 16'd1;
				c[CFG_ZERO_MIN]  = 16'd2;  c[CFG_ZERO_MAX]  = 16'd2;
				c[CFG_END_MIN]   = 16'd0;  c[CFG_REPEAT_MS] = 16'd0;
			end
			3: begin  // top of range: end pulses need the upper 16 width bits
				c[CFG_START_MIN] = 16'hFFFF;  c[CFG_START_MAX] = 16'hFFFF;
				c[CFG_ONE_MIN]   = 16'd60000; c[CFG_ONE_MAX]   = 16'd65534;
				c[CFG_ZERO_MIN]  = 16'd1;     c[CFG_ZERO_MAX]  = 16'd59999;
				c[CFG_END_MIN]   = 16'hFFFF;  c[CFG_REPEAT_MS] = 16'd2;
			end
			4: begin  // random windows, overlaps allowed
				for (int i = 0; i < NUM_CFG; i += 2) begin
					lo = 16'($urandom_range(65535, 0));
					c[i]   = lo;
					c[i+1] = lo + 16'($urandom_range(65535 - lo, 0));
				end
			end
			5: c[CFG_REPEAT_MS] = 16'd1000;
			default: ;
		endcase
		return c;
	endfunction

	task automatic apply_config(input cfg_t c);
		for (int i = 0; i < NUM_CFG; i++) begin
			write_reg(CFG_IDX_W'(i), c[i]);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// short directed opener on the reset windows
	task automatic run_directed();
		// field extremes while idle: both ignored
		send_pulse(32'h0000_0000, 32'h0000_0000);
		send_pulse(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// unit frame for code 0x6 -> unit 1, address only
		clock_ms = 32'd100;
		ms_step  = 2;
		send_frame(unit_pattern(4'h6, 1'b1), 10, end_w());
		// start pulse inside the repeat window re-issues it
		clock_ms = 32'd150;
		send_pulse(start_w(), clock_ms);
		// timestamp behind the last frame: timeout, no repeat, frame opens
		send_pulse(start_w(), 32'd140);
		send_pulse(one_w(), 32'd141);
		// width in no window and below end_min: bad pulse, back to idle
		send_pulse(32'd2600, 32'd142);
		// house frame accepted at timestamp zero leaves no last-frame time
		clock_ms = '0;
		ms_step  = 0;
		send_frame(house_pattern(4'hE), 8, end_w());
		ms_step  = 2;
	endtask

	task automatic random_sequence();
		int          pick;
		int          sub;
		int          nbits;
		logic [15:0] pat;
		logic [31:0] noise;
		pick = $urandom_range(99);
		if (pick < 35) begin
			advance_clock();
			send_frame(unit_pattern(4'($urandom), 1'($urandom)), 10, end_w());
		end else if (pick < 50) begin
			advance_clock();
			send_frame(house_pattern(4'($urandom)), 8, end_w());
		end else if (pick < 65) begin
			send_repeat();
		end else if (pick < 80) begin
			advance_clock();
			sub = $urandom_range(2);
			if (sub == 0) begin
				// random bit count, right or wrong
				send_frame(16'($urandom), $urandom_range(13, 0), end_w());
			end else if (sub == 1) begin
				// one complement pair broken
				if ($urandom_range(1)) begin
					pat   = unit_pattern(4'($urandom), 1'($urandom));
					nbits = 10;
				end else begin
					pat   = house_pattern(4'($urandom));
					nbits = 8;
				end
				pat = pat ^ (16'h8000 >> $urandom_range(nbits - 1, 0));
				send_frame(pat, nbits, end_w());
			end else begin
				// frame of up to ten bits closed by an arbitrary width
				send_frame(16'($urandom), $urandom_range(10, 0), $urandom_range(70000, 0));
			end
		end else if (pick < 90) begin
			advance_clock();
			send_frame(16'($urandom), $urandom_range(14, 11), end_w());
		end else begin
			noise = $urandom_range(1) ? $urandom : $urandom_range(20000, 0);
			send_pulse(noise, tick(), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int  target;
		int  midpoint;
		bit  paused;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		clock_ms    = '0;
		ms_step     = 2;
		pulses_sent = 0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// cfg only changes with the decoder drained
			wait_drained();
			apply_config(phase_config(phase));
			steady = (phase == 1);
			if (phase == 0) run_directed();
			if (phase == 5) hold_req = 1'b1;
			target   = pulses_sent + PHASE_PULSES;
			midpoint = pulses_sent + PHASE_PULSES / 2;
			paused   = 1'b0;
			while (pulses_sent < target) begin
				if (phase == 5 && !paused && pulses_sent >= midpoint) begin
					// sender stops until every command is out
					wait_drained();
					paused = 1'b1;
				end
				random_sequence();
			end
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
